// File: sv/ddss_pkg.sv
// ============================================================================
// ddss_pkg - shared types and constants for the duty step selector
// Word formats, register indexes, duty step codes and reset values.
// ============================================================================
package ddss_pkg;

    localparam int unsigned DEFAULT_TIME_BITS = 32;
    localparam int unsigned CFG_INDEX_BITS    = 2;
    localparam int unsigned CFG_DATA_BITS     = 32;

    localparam logic [31:0] RST_DEBOUNCE_MS = 32'd50;
    localparam logic [15:0] RST_WIDE_TOP    = 16'd320;
    localparam logic [7:0]  RST_NARROW_TOP  = 8'd40;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_DEBOUNCE   = 2'd0,
        CFG_WIDE_TOP   = 2'd1,
        CFG_NARROW_TOP = 2'd2
    } t_cfg_index;

    // duty steps, in stepping order
    typedef enum logic [2:0] {
        DUTY_0   = 3'd0,
        DUTY_25  = 3'd1,
        DUTY_50  = 3'd2,
        DUTY_75  = 3'd3,
        DUTY_100 = 3'd4
    } t_duty_step;

    typedef struct packed {
        logic        button_level;
        logic [31:0] now_ms;
    } t_in_word;

    typedef struct packed {
        logic [6:0]  duty_percent;
        logic [15:0] wide_compare;
        logic [7:0]  narrow_compare;
        logic        stable_level;
    } t_out_word;

    typedef struct packed {
        logic [31:0] debounce_ms;
        logic [15:0] wide_top;
        logic [7:0]  narrow_top;
    } t_cfg;

    // debouncer state after the current word
    typedef struct packed {
        logic       stable_level;
        t_duty_step step;
    } t_dbn_status;

    function automatic t_duty_step next_step(input t_duty_step s);
        t_duty_step r;
        unique case (s)
            DUTY_0:   r = DUTY_25;
            DUTY_25:  r = DUTY_50;
            DUTY_50:  r = DUTY_75;
            DUTY_75:  r = DUTY_100;
            DUTY_100: r = DUTY_0;
            default:  r = s;
        endcase
        return r;
    endfunction

    function automatic logic [6:0] step_percent(input t_duty_step s);
        logic [6:0] r;
        unique case (s)
            DUTY_0:   r = 7'd0;
            DUTY_25:  r = 7'd25;
            DUTY_50:  r = 7'd50;
            DUTY_75:  r = 7'd75;
            DUTY_100: r = 7'd100;
            default:  r = 7'd0;
        endcase
        return r;
    endfunction

endpackage

// File: sv/debounced_duty_step_selector.sv
// ============================================================================
// debounced_duty_step_selector - debounced button to fan duty selector
// Input register, debounce/duty update, result register with compare values.
// ============================================================================
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in): one word per button
//   sample, carrying the raw level and the millisecond time stamp.
//   Output channel (o_out_valid / i_out_ready / o_out): one word per input
//   word, with the duty in percent, the wide and narrow timer compare
//   values and the debounced level after that sample.
//   Config port (i_cfg_we / i_cfg_index / i_cfg_data): single-cycle writes
//   to debounce delay, wide top and narrow top; write only while idle.
// Path: the input register loads on the input accept; the result register
//   loads from it when the result stage is free or its word is taken.
//   Throughput: one word per cycle while the sink takes results; the
//   debounce compare, duty step and compare shift all settle in the cycle
//   between the two registers, with state updated as the word moves on.
// Reset: synchronous active low; both pipeline stages empty, stable level
//   low, duty 25 percent, config back to 50 ms / 320 / 40.
// Stall: a held result keeps the result register; the input register
//   still takes one more word, then o_in_ready drops until the sink drains.
// ============================================================================
module debounced_duty_step_selector #(
    parameter int unsigned TIME_BITS = ddss_pkg::DEFAULT_TIME_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  ddss_pkg::t_in_word                  i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output ddss_pkg::t_out_word                 o_out,
    input  logic                                i_cfg_we,
    input  logic [ddss_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [ddss_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);
    import ddss_pkg::*;

    // input stage
    logic        r_in_valid;
    t_in_word    r_in;
    // result stage
    logic        r_out_valid;
    t_out_word   r_out;

    t_cfg        w_cfg;
    t_dbn_status w_next;
    logic        w_advance;
    logic [6:0]  w_duty;
    logic [15:0] w_wide;
    logic [7:0]  w_narrow;

    // the held word moves to the result stage when that stage is free
    assign w_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;

    ddss_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // state commits only when the word leaves the input stage
    ddss_debounce #(
        .TIME_BITS (TIME_BITS)
    ) u_dbn (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_advance),
        .i_raw         (r_in.button_level),
        .i_now_ms      (r_in.now_ms),
        .i_debounce_ms (w_cfg.debounce_ms),
        .o_next        (w_next)
    );

    ddss_compare u_cmp (
        .i_step           (w_next.step),
        .i_wide_top       (w_cfg.wide_top),
        .i_narrow_top     (w_cfg.narrow_top),
        .o_duty_percent   (w_duty),
        .o_wide_compare   (w_wide),
        .o_narrow_compare (w_narrow)
    );

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in;
        end
        if (w_advance) begin
            r_out.duty_percent   <= w_duty;
            r_out.wide_compare   <= w_wide;
            r_out.narrow_compare <= w_narrow;
            r_out.stable_level   <= w_next.stable_level;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // a word in the input stage is never dropped while the result stalls
    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |=> r_in_valid)
        else $error("input stage lost a word under stall");

    // duty is always one of the five steps
    a_duty_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.duty_percent == 7'd0 || r_out.duty_percent == 7'd25 ||
                         r_out.duty_percent == 7'd50 || r_out.duty_percent == 7'd75 ||
                         r_out.duty_percent == 7'd100))
        else $error("duty outside the step set");

    // compare values never exceed their tops
    a_cmp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.wide_compare <= w_cfg.wide_top) &&
                        (r_out.narrow_compare <= w_cfg.narrow_top))
        else $error("compare value above its top");

endmodule

// File: sv/ddss_cfg_regs.sv
// ============================================================================
// ddss_cfg_regs - configuration register file
// Write-only registers for debounce delay and the two timer tops.
// ============================================================================
module ddss_cfg_regs (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [ddss_pkg::CFG_INDEX_BITS-1:0]    i_cfg_index,
    input  logic [ddss_pkg::CFG_DATA_BITS-1:0]     i_cfg_data,
    output ddss_pkg::t_cfg                         o_cfg
);
    import ddss_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms <= RST_DEBOUNCE_MS;
            r_cfg.wide_top    <= RST_WIDE_TOP;
            r_cfg.narrow_top  <= RST_NARROW_TOP;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_DEBOUNCE:   r_cfg.debounce_ms <= i_cfg_data;
                CFG_WIDE_TOP:   r_cfg.wide_top    <= i_cfg_data[15:0];
                CFG_NARROW_TOP: r_cfg.narrow_top  <= i_cfg_data[7:0];
                default: ;  // unused index, ignored
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: sv/ddss_debounce.sv
// ============================================================================
// ddss_debounce - debounce timer and duty stepper
// Tracks raw level changes, accepts a steady level, steps duty on press.
// ============================================================================
module ddss_debounce #(
    parameter int unsigned TIME_BITS = ddss_pkg::DEFAULT_TIME_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_raw,
    input  logic [31:0]            i_now_ms,
    input  logic [31:0]            i_debounce_ms,
    output ddss_pkg::t_dbn_status  o_next
);
    import ddss_pkg::*;

    localparam int unsigned CW = (TIME_BITS > 32) ? TIME_BITS : 32;

    logic                 r_prev_raw;
    logic                 r_stable;
    logic [TIME_BITS-1:0] r_change_time;
    t_duty_step           r_step;

    logic [CW-1:0]        w_now_ext;
    logic [TIME_BITS-1:0] w_now;
    logic                 w_change;
    logic [TIME_BITS-1:0] w_start;
    logic [TIME_BITS-1:0] w_elapsed;
    logic                 w_settled;
    logic                 n_stable;
    t_duty_step           n_step;

    assign w_now_ext = CW'(i_now_ms);
    assign w_now     = w_now_ext[TIME_BITS-1:0];
    assign w_change  = (i_raw != r_prev_raw);
    assign w_start   = w_change ? w_now : r_change_time;
    assign w_elapsed = w_now - w_start;
    assign w_settled = CW'(w_elapsed) > CW'(i_debounce_ms);

    always_comb begin
        n_stable = r_stable;
        n_step   = r_step;
        if (w_settled && (i_raw != r_stable)) begin
            n_stable = i_raw;
            if (i_raw) begin
                n_step = next_step(r_step);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_raw    <= 1'b0;
            r_stable      <= 1'b0;
            r_change_time <= '0;
            r_step        <= DUTY_25;
        end else if (i_en) begin
            r_prev_raw    <= i_raw;
            r_change_time <= w_start;
            r_stable      <= n_stable;
            r_step        <= n_step;
        end
    end

    assign o_next.stable_level = n_stable;
    assign o_next.step         = n_step;

    // duty only moves on a newly stable high level
    a_step_on_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step != $past(r_step)) |-> (r_stable && !$past(r_stable)))
        else $error("duty stepped without a rising stable level");

    // stable level only changes after a steady interval, never on a raw edge
    a_no_change_on_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && w_change) |-> (n_stable == r_stable))
        else $error("stable level changed on a raw transition");

    // a stalled debouncer keeps its state
    a_hold_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> (r_step == $past(r_step)) && (r_stable == $past(r_stable)))
        else $error("debouncer state moved without an enable");

endmodule

// File: sv/ddss_compare.sv
// ============================================================================
// ddss_compare - timer compare values from duty step
// Duty steps are quarters of full scale, so top*duty/100 is a shift form.
// ============================================================================
module ddss_compare (
    input  ddss_pkg::t_duty_step  i_step,
    input  logic [15:0]           i_wide_top,
    input  logic [7:0]            i_narrow_top,
    output logic [6:0]            o_duty_percent,
    output logic [15:0]           o_wide_compare,
    output logic [7:0]            o_narrow_compare
);
    import ddss_pkg::*;

    logic [17:0] w_wide_x3;
    logic [9:0]  w_narrow_x3;

    // 75 percent: floor(3*top/4)
    assign w_wide_x3   = {2'b00, i_wide_top} + {1'b0, i_wide_top, 1'b0};
    assign w_narrow_x3 = {2'b00, i_narrow_top} + {1'b0, i_narrow_top, 1'b0};

    assign o_duty_percent = step_percent(i_step);

    always_comb begin
        unique case (i_step)
            DUTY_0: begin
                o_wide_compare   = '0;
                o_narrow_compare = '0;
            end
            DUTY_25: begin
                o_wide_compare   = {2'b00, i_wide_top[15:2]};
                o_narrow_compare = {2'b00, i_narrow_top[7:2]};
            end
            DUTY_50: begin
                o_wide_compare   = {1'b0, i_wide_top[15:1]};
                o_narrow_compare = {1'b0, i_narrow_top[7:1]};
            end
            DUTY_75: begin
                o_wide_compare   = w_wide_x3[17:2];
                o_narrow_compare = w_narrow_x3[9:2];
            end
            DUTY_100: begin
                o_wide_compare   = i_wide_top;
                o_narrow_compare = i_narrow_top;
            end
            default: begin
                o_wide_compare   = '0;
                o_narrow_compare = '0;
            end
        endcase
    end

endmodule
